// ===== hw/rtl/jbt_pkg.sv =====
package jbt_pkg;

   // Offsets and lengths as shown on the result channel
   localparam int OFS_W = 24;

   // Lexer modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_STR,
      MODE_ESC,
      MODE_HEX,
      MODE_NUM,
      MODE_WORD
   } mode_type;

   typedef enum logic [3:0] {
      TOK_LBRACE   = 4'd0,
      TOK_LBRACKET = 4'd1,
      TOK_RBRACE   = 4'd2,
      TOK_RBRACKET = 4'd3,
      TOK_COLON    = 4'd4,
      TOK_COMMA    = 4'd5,
      TOK_STRING   = 4'd6,
      TOK_NUMBER   = 4'd7,
      TOK_TRUE     = 4'd8,
      TOK_FALSE    = 4'd9,
      TOK_NULL     = 4'd10
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_ILLEGAL  = 3'd1,
      ERR_NUMBER   = 3'd2,
      ERR_WORD     = 3'd3,
      ERR_ESCAPE   = 3'd4,
      ERR_UNTERM   = 3'd5
   } err_type;

   // Number grammar phases
   localparam logic [3:0] PH_NONE  = 4'd0;
   localparam logic [3:0] PH_MINUS = 4'd1;
   localparam logic [3:0] PH_ZERO  = 4'd2;
   localparam logic [3:0] PH_INT   = 4'd3;
   localparam logic [3:0] PH_DOT   = 4'd4;
   localparam logic [3:0] PH_FRAC  = 4'd5;
   localparam logic [3:0] PH_EMARK = 4'd6;
   localparam logic [3:0] PH_ESIGN = 4'd7;
   localparam logic [3:0] PH_EXP   = 4'd8;
   localparam logic [3:0] PH_END   = 4'd14;
   localparam logic [3:0] PH_BAD   = 4'd15;

   // Word kinds
   localparam logic [1:0] WK_TRUE  = 2'd0;
   localparam logic [1:0] WK_FALSE = 2'd1;
   localparam logic [1:0] WK_NULL  = 2'd2;

   // Characters
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_LOW_A    = 8'h61;
   localparam logic [7:0] CH_LOW_B    = 8'h62;
   localparam logic [7:0] CH_LOW_E    = 8'h65;
   localparam logic [7:0] CH_LOW_F    = 8'h66;
   localparam logic [7:0] CH_LOW_L    = 8'h6C;
   localparam logic [7:0] CH_LOW_N    = 8'h6E;
   localparam logic [7:0] CH_LOW_R    = 8'h72;
   localparam logic [7:0] CH_LOW_S    = 8'h73;
   localparam logic [7:0] CH_LOW_T    = 8'h74;
   localparam logic [7:0] CH_LOW_U    = 8'h75;
   localparam logic [7:0] CH_UP_A     = 8'h41;
   localparam logic [7:0] CH_UP_E     = 8'h45;
   localparam logic [7:0] CH_UP_F     = 8'h46;

   // One result item
   typedef struct packed {
      kind_type         kind;
      logic [OFS_W-1:0] start;
      logic [OFS_W-1:0] length;
      err_type          err;
      logic             last;
   } result_type;

   // Results produced by one byte, handed to the result queue
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
             (c >= CH_UP_A && c <= CH_UP_F);
   endfunction

   function automatic logic is_struct(input logic [7:0] c);
      return (c == CH_LBRACE) || (c == CH_LBRACKET) || (c == CH_RBRACE) ||
             (c == CH_RBRACKET) || (c == CH_COLON) || (c == CH_COMMA);
   endfunction

   function automatic kind_type struct_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CH_LBRACE:   k = TOK_LBRACE;
         CH_LBRACKET: k = TOK_LBRACKET;
         CH_RBRACE:   k = TOK_RBRACE;
         CH_RBRACKET: k = TOK_RBRACKET;
         CH_COLON:    k = TOK_COLON;
         default:     k = TOK_COMMA;
      endcase
      return k;
   endfunction

   function automatic logic num_can_end(input logic [3:0] ph);
      return (ph == PH_ZERO) || (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXP);
   endfunction

   // Next number phase for one byte
   function automatic logic [3:0] num_next(input logic [3:0] ph, input logic [7:0] c);
      logic       delim;
      logic       expo;
      logic       dig;
      logic [3:0] nx;
      delim = is_space(c) || (c == CH_RBRACE) || (c == CH_COMMA) || (c == CH_RBRACKET);
      expo  = (c == CH_LOW_E) || (c == CH_UP_E);
      dig   = is_digit(c);
      case (ph)
         PH_MINUS: nx = (c == CH_ZERO) ? PH_ZERO : (dig ? PH_INT : PH_BAD);
         PH_ZERO:  nx = (c == CH_DOT) ? PH_DOT : expo ? PH_EMARK :
                        delim ? PH_END : PH_BAD;
         PH_INT:   nx = (c == CH_DOT) ? PH_DOT : expo ? PH_EMARK :
                        delim ? PH_END : dig ? PH_INT : PH_BAD;
         PH_DOT:   nx = dig ? PH_FRAC : PH_BAD;
         PH_FRAC:  nx = dig ? PH_FRAC : expo ? PH_EMARK : delim ? PH_END : PH_BAD;
         PH_EMARK: nx = (c == CH_PLUS || c == CH_MINUS) ? PH_ESIGN :
                        dig ? PH_EXP : PH_BAD;
         PH_ESIGN: nx = dig ? PH_EXP : PH_BAD;
         PH_EXP:   nx = dig ? PH_EXP : delim ? PH_END : PH_BAD;
         default:  nx = PH_BAD;
      endcase
      return nx;
   endfunction

   function automatic logic [2:0] word_len(input logic [1:0] wk);
      logic [2:0] n;
      case (wk)
         WK_TRUE:  n = 3'd4;
         WK_FALSE: n = 3'd5;
         WK_NULL:  n = 3'd4;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic kind_type word_tok(input logic [1:0] wk);
      kind_type k;
      case (wk)
         WK_TRUE:  k = TOK_TRUE;
         WK_FALSE: k = TOK_FALSE;
         default:  k = TOK_NULL;
      endcase
      return k;
   endfunction

   // Letter of a word at a position; only read below the word's length
   function automatic logic [7:0] word_char(input logic [1:0] wk, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      case (wk)
         WK_TRUE: begin
            case (idx)
               3'd0:    ch = CH_LOW_T;
               3'd1:    ch = CH_LOW_R;
               3'd2:    ch = CH_LOW_U;
               default: ch = CH_LOW_E;
            endcase
         end
         WK_FALSE: begin
            case (idx)
               3'd0:    ch = CH_LOW_F;
               3'd1:    ch = CH_LOW_A;
               3'd2:    ch = CH_LOW_L;
               3'd3:    ch = CH_LOW_S;
               default: ch = CH_LOW_E;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    ch = CH_LOW_N;
               3'd1:    ch = CH_LOW_U;
               default: ch = CH_LOW_L;
            endcase
         end
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/jbt_lexer.sv =====
module jbt_lexer
   import jbt_pkg::*;
#(
   parameter int POS_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] byte_in,
   input  logic       doc_end,
   output push_type   push
);

   mode_type            mode_ff,  mode_in;
   logic [3:0]          phase_ff, phase_in;
   logic [2:0]          hex_ff,   hex_in;
   logic [1:0]          wkind_ff, wkind_in;
   logic [2:0]          widx_ff,  widx_in;
   logic [POS_BITS-1:0] pos_ff,   pos_in;
   logic [POS_BITS-1:0] begin_ff, begin_in;
   logic                hold_ff,  hold_in;

   logic [POS_BITS-1:0] pos_inc;
   logic [3:0]          num_nx;
   logic                start_en;
   err_type             fault;
   logic                tok_v, st_v, end_v;
   result_type          tok_r, st_r, end_r, err_r;
   logic [1:0]          cnt;

   assign pos_inc = POS_BITS'(pos_ff + 1'b1);
   assign num_nx  = num_next(phase_ff, byte_in);

   // Per-byte lexing: mode step, token start, end of document, error
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      hex_in   = hex_ff;
      wkind_in = wkind_ff;
      widx_in  = widx_ff;
      begin_in = begin_ff;
      hold_in  = hold_ff;
      pos_in   = pos_inc;
      start_en = 1'b0;
      fault    = ERR_NONE;
      tok_v    = 1'b0;
      st_v     = 1'b0;
      end_v    = 1'b0;
      tok_r    = '0;
      st_r     = '0;
      end_r    = '0;
      err_r    = '0;

      if (!hold_ff) begin
         unique case (mode_ff)
            MODE_IDLE: start_en = 1'b1;
            MODE_STR: begin
               if (byte_in == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else if (byte_in == CH_QUOTE) begin
                  tok_v        = 1'b1;
                  tok_r.kind   = TOK_STRING;
                  tok_r.start  = OFS_W'(begin_ff);
                  tok_r.length = OFS_W'(POS_BITS'(pos_ff - begin_ff));
                  mode_in      = MODE_IDLE;
               end
            end
            MODE_ESC: begin
               case (byte_in) inside
                  CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F,
                  CH_LOW_N, CH_LOW_R, CH_LOW_T: mode_in = MODE_STR;
                  CH_LOW_U: begin
                     mode_in = MODE_HEX;
                     hex_in  = 3'd4;
                  end
                  default: fault = ERR_ESCAPE;
               endcase
            end
            MODE_HEX: begin
               if (is_hex(byte_in)) begin
                  hex_in = hex_ff - 1'b1;
                  if (hex_ff == 3'd1) begin
                     mode_in = MODE_STR;
                  end
               end else begin
                  fault = ERR_ESCAPE;
               end
            end
            MODE_NUM: begin
               if (num_nx == PH_END) begin
                  tok_v        = 1'b1;
                  tok_r.kind   = TOK_NUMBER;
                  tok_r.start  = OFS_W'(begin_ff);
                  tok_r.length = OFS_W'(POS_BITS'(pos_ff - begin_ff));
                  mode_in      = MODE_IDLE;
                  phase_in     = PH_NONE;
                  start_en     = 1'b1;
               end else if (num_nx == PH_BAD) begin
                  fault = ERR_NUMBER;
               end else begin
                  phase_in = num_nx;
               end
            end
            MODE_WORD: begin
               if ((widx_ff < word_len(wkind_ff)) &&
                   (byte_in == word_char(wkind_ff, widx_ff))) begin
                  widx_in = widx_ff + 1'b1;
                  if (widx_in == word_len(wkind_ff)) begin
                     tok_v        = 1'b1;
                     tok_r.kind   = word_tok(wkind_ff);
                     tok_r.start  = OFS_W'(begin_ff);
                     tok_r.length = OFS_W'(word_len(wkind_ff));
                     mode_in      = MODE_IDLE;
                     widx_in      = 3'd0;
                  end
               end else begin
                  fault = ERR_WORD;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase

         // Start of a new token from the between-tokens mode, or from the byte that closes a number
         if (start_en) begin
            if (is_space(byte_in)) begin
               // nothing to do
            end else if (is_struct(byte_in)) begin
               st_v        = 1'b1;
               st_r.kind   = struct_kind(byte_in);
               st_r.start  = OFS_W'(pos_ff);
               st_r.length = OFS_W'(1);
            end else if (byte_in == CH_QUOTE) begin
               mode_in  = MODE_STR;
               begin_in = pos_inc;
            end else if (byte_in == CH_MINUS || is_digit(byte_in)) begin
               mode_in  = MODE_NUM;
               begin_in = pos_ff;
               phase_in = (byte_in == CH_MINUS) ? PH_MINUS :
                          (byte_in == CH_ZERO) ? PH_ZERO : PH_INT;
            end else if (byte_in == CH_DOT) begin
               fault = ERR_NUMBER;
            end else if (byte_in == CH_LOW_T || byte_in == CH_LOW_F ||
                         byte_in == CH_LOW_N) begin
               mode_in  = MODE_WORD;
               begin_in = pos_ff;
               wkind_in = (byte_in == CH_LOW_T) ? WK_TRUE :
                          (byte_in == CH_LOW_F) ? WK_FALSE : WK_NULL;
               widx_in  = 3'd1;
            end else begin
               fault = ERR_ILLEGAL;
            end
         end

         // End of document closes or rejects whatever is open
         if (fault == ERR_NONE && doc_end) begin
            if (mode_in == MODE_STR || mode_in == MODE_ESC || mode_in == MODE_HEX) begin
               fault = ERR_UNTERM;
            end else if (mode_in == MODE_NUM) begin
               if (num_can_end(phase_in)) begin
                  end_v        = 1'b1;
                  end_r.kind   = TOK_NUMBER;
                  end_r.start  = OFS_W'(begin_in);
                  end_r.length = OFS_W'(POS_BITS'(pos_inc - begin_in));
               end else begin
                  fault = ERR_UNTERM;
               end
            end else if (mode_in == MODE_WORD) begin
               fault = ERR_WORD;
            end
         end

         if (fault != ERR_NONE) begin
            err_r.kind  = TOK_LBRACE;
            err_r.start = OFS_W'(pos_ff);
            err_r.err   = fault;
            hold_in     = 1'b1;
            mode_in     = MODE_IDLE;
         end
      end

      // Every document starts afresh at offset zero
      if (doc_end) begin
         mode_in  = MODE_IDLE;
         phase_in = PH_NONE;
         hex_in   = '0;
         wkind_in = '0;
         widx_in  = '0;
         pos_in   = '0;
         begin_in = '0;
         hold_in  = 1'b0;
      end
   end

   // Order the results; an error never shares a byte with a token
   always_comb begin
      push = '0;
      if (hold_ff) begin
         cnt = 2'd0;
      end else if (fault != ERR_NONE) begin
         cnt = 2'd1;
      end else begin
         cnt = 2'(tok_v) + 2'(st_v) + 2'(end_v);
      end
      push.count  = take ? cnt : 2'd0;
      push.first  = tok_v ? tok_r : st_v ? st_r : end_v ? end_r : err_r;
      push.first.last = (cnt == 2'd1);
      push.second = st_r;
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= PH_NONE;
         hex_ff   <= '0;
         wkind_ff <= '0;
         widx_ff  <= '0;
         pos_ff   <= '0;
         begin_ff <= '0;
         hold_ff  <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         wkind_ff <= wkind_in;
         widx_ff  <= widx_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

// ===== hw/rtl/jbt_result_fifo.sv =====
module jbt_result_fifo
   import jbt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic       not_empty,
   output logic       room2,
   output result_type head
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   result_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   logic [PTR_W-1:0]   wr_next;
   logic               do_pop;

   assign not_empty = (cnt_ff != '0);
   assign room2     = (cnt_ff <= (PTR_W+1)'(DEPTH - 2));
   assign head      = mem_ff[rd_ff];
   assign do_pop    = pop && not_empty;
   assign wr_next   = PTR_W'(wr_ff + 1'b1);

   // Pointer and fill bookkeeping, up to two writes per cycle
   always_comb begin
      wr_in  = PTR_W'(wr_ff + push.count);
      rd_in  = do_pop ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = (PTR_W+1)'(cnt_ff + (PTR_W+1)'(push.count) - (PTR_W+1)'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== hw/rtl/json_byte_tokenizer.sv =====
// An accepted byte waits in the input register; its results go into the result queue,
//   whose head drives rsp_. Throughput: one byte per cycle while the queue has room
//   for two results; a number closed by a structural byte gives two results, which the
//   4-entry result queue absorbs; bytes stall only when rsp_stall leaves over two queued.
// Reset (synchronous, active high): lexer between tokens at offset zero, input
//   register and result queue empty.
module json_byte_tokenizer
   import jbt_pkg::*;
#(
   parameter int POS_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_doc_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [23:0] rsp_token_start,
   output logic [23:0] rsp_token_length,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_run_last
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_end_ff;
   logic       take;
   logic       accept;
   logic       room2;
   push_type   push;
   result_type head;

   // Input register advances when the queue has room for two results
   assign take      = s1_valid_ff && room2;
   assign req_stall = s1_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_byte_in;
         s1_end_ff  <= req_doc_end;
      end
   end

   jbt_lexer #(
      .POS_BITS (POS_BITS)
   ) u_lexer (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .byte_in (s1_byte_ff),
      .doc_end (s1_end_ff),
      .push    (push)
   );

   jbt_result_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .not_empty (rsp_valid),
      .room2     (room2),
      .head      (head)
   );

   // Result channel fields
   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_error_code   = head.err;
   assign rsp_run_last     = head.last;

endmodule

// ===== hw/rtl/jbt_checker.sv =====
module jbt_checker
   import jbt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_byte_in,
   input logic        req_doc_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_token_kind,
   input logic [23:0] rsp_token_start,
   input logic [23:0] rsp_token_length,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_run_last
);

   // Nothing is presented right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // An error result is alone on its byte and carries no token text
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |->
         (rsp_token_kind == TOK_LBRACE && rsp_token_length == '0 && rsp_run_last))
      else $error("malformed error result");

   // Only a number can be followed by another result from the same byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_run_last) |-> (rsp_token_kind == TOK_NUMBER))
      else $error("non-number result not last of its byte");

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled byte transfer stays offered unchanged
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_byte_in) && $stable(req_doc_end)))
      else $error("byte changed while stalled");

endmodule

bind json_byte_tokenizer jbt_checker u_checker (.*);
